@@ hw/rtl/shp_pkg.sv @@
package shp_pkg;

  localparam int REQ_BITS = 20;
  localparam logic [REQ_BITS-1:0] RESET_REQUEST = 20'd4072;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [1:0] FIT_BEST  = 2'd0;
  localparam logic [1:0] FIT_WORST = 2'd1;
  localparam logic [1:0] FIT_FIRST = 2'd2;
  localparam logic [1:0] FIT_NEXT  = 2'd3;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NO_FIT   = 3'd1;
  localparam logic [2:0] ST_BAD_SIZE = 3'd2;
  localparam logic [2:0] ST_BAD_ADDR = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;

  typedef enum logic [2:0] {
    CM_KEEP,
    CM_UP,
    CM_DOWN,
    CM_SET,
    CM_LOAD,
    CM_CLEAR
  } cell_mode_t;

  typedef struct packed {
    cell_mode_t mode;
  } cell_ctl_t;

endpackage

@@ hw/rtl/shp_cell.sv @@
module shp_cell #(
  parameter int ADDR_BITS = 20
) (
  input  logic                  clk,
  input  shp_pkg::cell_ctl_t    ctl,
  input  logic [ADDR_BITS-1:0]  up_start,
  input  logic [ADDR_BITS-1:0]  up_size,
  input  logic                  up_free,
  input  logic [ADDR_BITS-1:0]  dn_start,
  input  logic [ADDR_BITS-1:0]  dn_size,
  input  logic                  dn_free,
  input  logic [ADDR_BITS-1:0]  set_size,
  input  logic                  set_free,
  input  logic [ADDR_BITS-1:0]  ld_start,
  input  logic [ADDR_BITS-1:0]  ld_size,
  input  logic                  ld_free,
  output logic [ADDR_BITS-1:0]  start,
  output logic [ADDR_BITS-1:0]  size,
  output logic                  is_free
);
  import shp_pkg::*;

  logic [ADDR_BITS-1:0] start_r, start_nxt, size_r, size_nxt;
  logic                 free_r, free_nxt;

  always_comb begin
    start_nxt = start_r;
    size_nxt  = size_r;
    free_nxt  = free_r;
    case (ctl.mode)
      CM_UP: begin
        start_nxt = up_start;
        size_nxt  = up_size;
        free_nxt  = up_free;
      end
      CM_DOWN: begin
        start_nxt = dn_start;
        size_nxt  = dn_size;
        free_nxt  = dn_free;
      end
      CM_SET: begin
        size_nxt = set_size;
        free_nxt = set_free;
      end
      CM_LOAD: begin
        start_nxt = ld_start;
        size_nxt  = ld_size;
        free_nxt  = ld_free;
      end
      CM_CLEAR: begin
        start_nxt = '0;
        size_nxt  = '0;
        free_nxt  = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    start_r <= start_nxt;
    size_r  <= size_nxt;
    free_r  <= free_nxt;
  end

  assign start   = start_r;
  assign size    = size_r;
  assign is_free = free_r;

endmodule

@@ hw/rtl/segment_heap_allocator.sv @@
// Segment heap allocator. The segment table lives in a ring of MAX_SEGMENTS
// cells. Every command but a zero-size allocate rotates the ring once round,
// inspecting one entry per cycle at cell 0, then applies the update in
// S_APPLY1 (a split or a merge shifts the cells beyond the entry by one place
// at once); a free that merges with the preceding segment also passes through
// S_APPLY2. A zero-size allocate goes straight to S_RESP with ST_BAD_SIZE.
// One item is in flight at a time. A configuration write re-initialises the
// table in the same cycle. PAGE_BYTES must be a power of two.
module segment_heap_allocator #(
  parameter int MAX_SEGMENTS = 64,
  parameter int HEADER_BYTES = 24,
  parameter int PAGE_BYTES   = 4096,
  parameter int ADDR_BITS    = 20
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [shp_pkg::REQ_BITS-1:0]  cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_cmd,
  input  logic [shp_pkg::REQ_BITS-1:0]  in_req_size,
  input  logic [1:0]                    in_fit_mode,
  input  logic [shp_pkg::REQ_BITS-1:0]  in_free_address,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [2:0]                    out_status,
  output logic [shp_pkg::REQ_BITS-1:0]  out_payload_address,
  output logic [shp_pkg::REQ_BITS-1:0]  out_granted_size
);
  import shp_pkg::*;

  localparam int W  = ADDR_BITS;
  localparam int N  = MAX_SEGMENTS;
  localparam int IW = $clog2(N);
  localparam int CW = $clog2(N + 1);
  localparam int MW = ((W > REQ_BITS) ? W : REQ_BITS) + 2;
  localparam longint unsigned CAP = ((64'd1 << W) / PAGE_BYTES) * PAGE_BYTES;
  localparam logic [MW-1:0] CAP_M = MW'(CAP);
  localparam logic [MW-1:0] HDR_M = MW'(HEADER_BYTES);
  localparam logic [MW-1:0] PMASK = MW'(PAGE_BYTES - 1);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SCAN   = 5'b00010,
    S_APPLY1 = 5'b00100,
    S_APPLY2 = 5'b01000,
    S_RESP   = 5'b10000
  } state_t;

  function automatic logic [W:0] init_seg(input logic [REQ_BITS-1:0] r);
    logic [MW-1:0] t;
    t = MW'(r) + HDR_M;
    t = (t + PMASK) & ~PMASK;
    if (t > CAP_M) t = CAP_M;
    if (r == '0 || t <= HDR_M) return '0;
    return {1'b1, W'(t - HDR_M)};
  endfunction

  function automatic logic [IW-1:0] nf_drop(input logic [IW-1:0] nf, input logic [CW-1:0] j);
    if (CW'(nf) >= j && nf != '0) return nf - 1'b1;
    return nf;
  endfunction

  state_t state_r, state_nxt;

  logic [W-1:0] c_start [N];
  logic [W-1:0] c_size  [N];
  logic         c_free  [N];
  cell_ctl_t    ctl     [N];

  logic [W-1:0] set_size, ld_start, ld_size;
  logic         set_free, ld_free;

  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic [IW-1:0]       nf_r, nf_nxt, step_r, step_nxt;
  logic                cmd_r, cmd_nxt;
  logic [REQ_BITS-1:0] req_r, req_nxt, addr_r, addr_nxt;
  logic [1:0]          mode_r, mode_nxt;
  logic [CW-1:0]       sidx_r, sidx_nxt;
  logic                found_r, found_nxt, alt_found_r, alt_found_nxt;
  logic [IW-1:0]       pick_r, pick_nxt, alt_pick_r, alt_pick_nxt;
  logic [W-1:0]        psize_r, psize_nxt, pstart_r, pstart_nxt;
  logic [W-1:0]        alt_size_r, alt_size_nxt, alt_start_r, alt_start_nxt;
  logic                last_free_r, last_free_nxt, prev_free_r, prev_free_nxt;
  logic [W-1:0]        last_size_r, last_size_nxt, prev_size_r, prev_size_nxt;
  logic                just_m_r, just_m_nxt, nxt_free_r, nxt_free_nxt;
  logic [W-1:0]        nsize_r, nsize_nxt, ms_r, ms_nxt;
  logic [2:0]          res_status_r, res_status_nxt;
  logic [REQ_BITS-1:0] res_addr_r, res_addr_nxt, res_size_r, res_size_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [2:0]          out_status_r, out_status_nxt;
  logic [REQ_BITS-1:0] out_addr_r, out_addr_nxt, out_size_r, out_size_nxt;

  logic                cfg_xfer, in_xfer, init_now;
  logic [REQ_BITS-1:0] init_req;
  logic [W:0]          init_val;
  logic [CW-1:0]       tc;
  logic                ent_v, fits, match;
  logic                e_found;
  logic [IW-1:0]       e_idx;
  logic [W-1:0]        e_size, e_start;
  logic                split, merge_n;
  logic [W-1:0]        paddr_w, msum;

  assign cfg_ready = (state_r == S_IDLE);
  assign in_ready  = (state_r == S_IDLE) && !cfg_valid;
  assign cfg_xfer  = cfg_valid && cfg_ready;
  assign in_xfer   = in_valid && in_ready;
  assign init_now  = !rst_n || cfg_xfer;
  assign init_req  = rst_n ? cfg_data : RESET_REQUEST;
  assign init_val  = init_seg(init_req);

  assign tc    = CW'(step_r);
  assign ent_v = tc < cnt_r;
  assign fits  = ent_v && c_free[0] && (MW'(c_size[0]) >= MW'(req_r));
  assign match = ent_v && !c_free[0] && (MW'(c_start[0]) + HDR_M == MW'(addr_r));

  always_comb begin
    e_found = found_r;
    e_idx   = pick_r;
    e_size  = psize_r;
    e_start = pstart_r;
    if (mode_r == FIT_NEXT && !found_r) begin
      e_found = alt_found_r;
      e_idx   = alt_pick_r;
      e_size  = alt_size_r;
      e_start = alt_start_r;
    end
  end

  assign split   = MW'(e_size) > MW'(req_r) + HDR_M;
  assign merge_n = nxt_free_r;
  assign paddr_w = W'(MW'(e_start) + HDR_M);
  assign msum    = W'(MW'(psize_r) + MW'(nsize_r) + HDR_M);

  genvar g;
  generate
    for (g = 0; g < N; g++) begin : g_cell
      localparam int UP = (g + 1) % N;
      localparam int DN = (g + N - 1) % N;
      shp_cell #(.ADDR_BITS(W)) u_cell (
        .clk      (clk),
        .ctl      (ctl[g]),
        .up_start (c_start[UP]),
        .up_size  (c_size[UP]),
        .up_free  (c_free[UP]),
        .dn_start (c_start[DN]),
        .dn_size  (c_size[DN]),
        .dn_free  (c_free[DN]),
        .set_size (set_size),
        .set_free (set_free),
        .ld_start (ld_start),
        .ld_size  (ld_size),
        .ld_free  (ld_free),
        .start    (c_start[g]),
        .size     (c_size[g]),
        .is_free  (c_free[g])
      );
    end
  endgenerate

  always_comb begin
    for (int k = 0; k < N; k++) ctl[k].mode = CM_KEEP;
    set_size = '0;
    set_free = 1'b0;
    ld_start = '0;
    ld_size  = '0;
    ld_free  = 1'b0;
    if (init_now) begin
      ld_size = init_val[W-1:0];
      ld_free = init_val[W];
      for (int k = 0; k < N; k++) ctl[k].mode = (k == 0) ? CM_LOAD : CM_CLEAR;
    end else if (state_r == S_SCAN) begin
      for (int k = 0; k < N; k++) ctl[k].mode = CM_UP;
    end else if (state_r == S_APPLY1 && e_found) begin
      if (cmd_r == CMD_ALLOC) begin
        set_free = 1'b0;
        if (!split) begin
          set_size = e_size;
          for (int k = 0; k < N; k++)
            if (CW'(k) == CW'(e_idx)) ctl[k].mode = CM_SET;
        end else if (cnt_r < CW'(N)) begin
          set_size = W'(req_r);
          ld_start = W'(MW'(e_start) + HDR_M + MW'(req_r));
          ld_size  = W'(MW'(e_size) - MW'(req_r) - HDR_M);
          ld_free  = 1'b1;
          for (int k = 0; k < N; k++) begin
            if (CW'(k) == CW'(e_idx)) ctl[k].mode = CM_SET;
            else if (CW'(k) == CW'(e_idx) + 1'b1) ctl[k].mode = CM_LOAD;
            else if (CW'(k) > CW'(e_idx) + 1'b1) ctl[k].mode = CM_DOWN;
          end
        end
      end else begin
        set_free = 1'b1;
        set_size = merge_n ? msum : psize_r;
        for (int k = 0; k < N; k++) begin
          if (CW'(k) == CW'(pick_r)) ctl[k].mode = CM_SET;
          else if (merge_n && k == N - 1) ctl[k].mode = CM_CLEAR;
          else if (merge_n && CW'(k) > CW'(pick_r)) ctl[k].mode = CM_UP;
        end
      end
    end else if (state_r == S_APPLY2) begin
      set_free = 1'b1;
      set_size = W'(MW'(prev_size_r) + MW'(ms_r) + HDR_M);
      for (int k = 0; k < N; k++) begin
        if (CW'(k) + 1'b1 == CW'(pick_r)) ctl[k].mode = CM_SET;
        else if (k == N - 1) ctl[k].mode = CM_CLEAR;
        else if (CW'(k) >= CW'(pick_r)) ctl[k].mode = CM_UP;
      end
    end
  end

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    nf_nxt         = nf_r;
    step_nxt       = step_r;
    cmd_nxt        = cmd_r;
    req_nxt        = req_r;
    addr_nxt       = addr_r;
    mode_nxt       = mode_r;
    sidx_nxt       = sidx_r;
    found_nxt      = found_r;
    alt_found_nxt  = alt_found_r;
    pick_nxt       = pick_r;
    alt_pick_nxt   = alt_pick_r;
    psize_nxt      = psize_r;
    pstart_nxt     = pstart_r;
    alt_size_nxt   = alt_size_r;
    alt_start_nxt  = alt_start_r;
    last_free_nxt  = last_free_r;
    last_size_nxt  = last_size_r;
    prev_free_nxt  = prev_free_r;
    prev_size_nxt  = prev_size_r;
    just_m_nxt     = just_m_r;
    nxt_free_nxt   = nxt_free_r;
    nsize_nxt      = nsize_r;
    ms_nxt         = ms_r;
    res_status_nxt = res_status_r;
    res_addr_nxt   = res_addr_r;
    res_size_nxt   = res_size_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_addr_nxt   = out_addr_r;
    out_size_nxt   = out_size_r;

    case (state_r)
      S_IDLE: begin
        if (cfg_xfer) begin
          cnt_nxt = CW'(init_val[W]);
          nf_nxt  = '0;
        end else if (in_xfer) begin
          cmd_nxt       = in_cmd;
          req_nxt       = in_req_size;
          addr_nxt      = in_free_address;
          mode_nxt      = in_fit_mode;
          step_nxt      = '0;
          found_nxt     = 1'b0;
          alt_found_nxt = 1'b0;
          last_free_nxt = 1'b0;
          prev_free_nxt = 1'b0;
          just_m_nxt    = 1'b0;
          nxt_free_nxt  = 1'b0;
          sidx_nxt      = '0;
          if (in_fit_mode == FIT_NEXT && CW'(nf_r) + 1'b1 < cnt_r)
            sidx_nxt = CW'(nf_r) + 1'b1;
          if (in_cmd == CMD_ALLOC && in_req_size == '0) begin
            res_status_nxt = ST_BAD_SIZE;
            res_addr_nxt   = '0;
            res_size_nxt   = '0;
            state_nxt      = S_RESP;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (cmd_r == CMD_ALLOC) begin
          case (mode_r)
            FIT_BEST: begin
              if (fits && (!found_r || c_size[0] < psize_r)) begin
                found_nxt = 1'b1; pick_nxt = step_r;
                psize_nxt = c_size[0]; pstart_nxt = c_start[0];
              end
            end
            FIT_WORST: begin
              if (fits && (!found_r || c_size[0] > psize_r)) begin
                found_nxt = 1'b1; pick_nxt = step_r;
                psize_nxt = c_size[0]; pstart_nxt = c_start[0];
              end
            end
            FIT_FIRST: begin
              if (fits && !found_r) begin
                found_nxt = 1'b1; pick_nxt = step_r;
                psize_nxt = c_size[0]; pstart_nxt = c_start[0];
              end
            end
            default: begin
              if (fits && !found_r && tc >= sidx_r) begin
                found_nxt = 1'b1; pick_nxt = step_r;
                psize_nxt = c_size[0]; pstart_nxt = c_start[0];
              end
              if (fits && !alt_found_r) begin
                alt_found_nxt = 1'b1; alt_pick_nxt = step_r;
                alt_size_nxt = c_size[0]; alt_start_nxt = c_start[0];
              end
            end
          endcase
        end else begin
          if (match) begin
            found_nxt     = 1'b1;
            pick_nxt      = step_r;
            psize_nxt     = c_size[0];
            prev_free_nxt = (step_r != '0) && last_free_r;
            prev_size_nxt = last_size_r;
          end
          just_m_nxt = match;
          if (just_m_r && ent_v) begin
            nxt_free_nxt = c_free[0];
            nsize_nxt    = c_size[0];
          end
        end
        last_free_nxt = ent_v && c_free[0];
        last_size_nxt = c_size[0];
        step_nxt      = step_r + 1'b1;
        if (step_r == IW'(N - 1)) state_nxt = S_APPLY1;
      end
      S_APPLY1: begin
        state_nxt      = S_RESP;
        res_status_nxt = ST_OK;
        res_addr_nxt   = '0;
        res_size_nxt   = '0;
        if (cmd_r == CMD_ALLOC) begin
          if (!e_found) begin
            res_status_nxt = ST_NO_FIT;
          end else if (split && cnt_r >= CW'(N)) begin
            res_status_nxt = ST_FULL;
          end else begin
            res_addr_nxt = REQ_BITS'(paddr_w);
            if (split) begin
              res_size_nxt = req_r;
              cnt_nxt      = cnt_r + 1'b1;
              nf_nxt       = e_idx + 1'b1;
            end else begin
              res_size_nxt = REQ_BITS'(e_size);
              nf_nxt       = e_idx;
            end
          end
        end else begin
          if (!found_r) begin
            res_status_nxt = ST_BAD_ADDR;
          end else begin
            res_addr_nxt = addr_r;
            res_size_nxt = REQ_BITS'(psize_r);
            ms_nxt       = merge_n ? msum : psize_r;
            if (merge_n) begin
              cnt_nxt = cnt_r - 1'b1;
              nf_nxt  = nf_drop(nf_r, CW'(pick_r) + 1'b1);
            end
            if (prev_free_r) state_nxt = S_APPLY2;
          end
        end
      end
      S_APPLY2: begin
        cnt_nxt   = cnt_r - 1'b1;
        nf_nxt    = nf_drop(nf_r, CW'(pick_r));
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_addr_nxt   = res_addr_r;
          out_size_nxt   = res_size_r;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= CW'(init_val[W]);
      nf_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      nf_r        <= nf_nxt;
      out_valid_r <= out_valid_nxt;
    end
    step_r       <= step_nxt;
    cmd_r        <= cmd_nxt;
    req_r        <= req_nxt;
    addr_r       <= addr_nxt;
    mode_r       <= mode_nxt;
    sidx_r       <= sidx_nxt;
    found_r      <= found_nxt;
    alt_found_r  <= alt_found_nxt;
    pick_r       <= pick_nxt;
    alt_pick_r   <= alt_pick_nxt;
    psize_r      <= psize_nxt;
    pstart_r     <= pstart_nxt;
    alt_size_r   <= alt_size_nxt;
    alt_start_r  <= alt_start_nxt;
    last_free_r  <= last_free_nxt;
    last_size_r  <= last_size_nxt;
    prev_free_r  <= prev_free_nxt;
    prev_size_r  <= prev_size_nxt;
    just_m_r     <= just_m_nxt;
    nxt_free_r   <= nxt_free_nxt;
    nsize_r      <= nsize_nxt;
    ms_r         <= ms_nxt;
    res_status_r <= res_status_nxt;
    res_addr_r   <= res_addr_nxt;
    res_size_r   <= res_size_nxt;
    out_status_r <= out_status_nxt;
    out_addr_r   <= out_addr_nxt;
    out_size_r   <= out_size_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_payload_address = out_addr_r;
  assign out_granted_size    = out_size_r;

endmodule
